// ----- rtl/rmt_pkg.sv -----
package rmt_pkg;

	localparam int OPCODE_W = 3;
	localparam int BASE_W   = 12;
	localparam int SLOT_W   = 3;
	localparam int COUNT_W  = 4;
	localparam int VALUE_W  = 32;
	localparam int ITER_W   = 31;
	localparam int PROB_W   = 17;
	localparam int AIDX_W   = 3;
	localparam int FRAC_W   = 16;

	localparam logic [OPCODE_W-1:0] OP_ADD_REGRET  = 3'd0;
	localparam logic [OPCODE_W-1:0] OP_ADD_WEIGHT  = 3'd1;
	localparam logic [OPCODE_W-1:0] OP_RM_QUERY    = 3'd2;
	localparam logic [OPCODE_W-1:0] OP_AVG_QUERY   = 3'd3;
	localparam logic [OPCODE_W-1:0] OP_DISCOUNT    = 3'd4;

	localparam logic ST_OK    = 1'b0;
	localparam logic ST_ORDER = 1'b1;

	localparam logic [PROB_W-1:0] Q16_ONE = 17'd65536;

	localparam logic [VALUE_W-1:0] SAT_MAX = 32'h7fff_ffff;
	localparam logic [VALUE_W-1:0] SAT_MIN = 32'h8000_0000;

	typedef enum logic [4:0] {
		S_CLEAR,
		S_IDLE,
		S_REDUCE,
		S_ADD_RD,
		S_ADD_WR,
		S_SUM_RD,
		S_SUM_ACC,
		S_Q_RD,
		S_Q_DIV,
		S_Q_WAIT,
		S_Q_EMIT,
		S_D_RD,
		S_D_MUL,
		S_D_DIV,
		S_D_WAIT,
		S_D_WR,
		S_D_EMIT,
		S_ERR_EMIT
	} rmt_state_t;

endpackage

// ----- rtl/rmt_req_if.sv -----
interface rmt_req_if;
	logic                                 valid;
	logic                                 ready;
	logic [rmt_pkg::OPCODE_W-1:0]         opcode;
	logic [rmt_pkg::BASE_W-1:0]           base_index;
	logic [rmt_pkg::SLOT_W-1:0]           action_slot;
	logic [rmt_pkg::COUNT_W-1:0]          action_count;
	logic signed [rmt_pkg::VALUE_W-1:0]   value;
	logic [rmt_pkg::ITER_W-1:0]           iteration;

	modport source (output valid, opcode, base_index, action_slot, action_count, value,
		iteration, input ready);
	modport sink (input valid, opcode, base_index, action_slot, action_count, value,
		iteration, output ready);
endinterface

// ----- rtl/rmt_rsp_if.sv -----
interface rmt_rsp_if;
	logic                          valid;
	logic                          ready;
	logic [rmt_pkg::PROB_W-1:0]    probability;
	logic [rmt_pkg::AIDX_W-1:0]    action_index;
	logic                          last;
	logic                          status;

	modport source (output valid, probability, action_index, last, status, input ready);
	modport sink (input valid, probability, action_index, last, status, output ready);
endinterface

// ----- rtl/rmt_div.sv -----
module rmt_div #(
	parameter int VW = 32,
	parameter int QW = 32
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	input  logic [VW+QW-1:0] dividend,
	input  logic [VW-1:0]    divisor,
	output logic             busy,
	output logic [QW-1:0]    quotient
);

	localparam int CW = $clog2(QW + 1);

	logic [VW-1:0] rem_q;
	logic [QW-1:0] quo_q;
	logic [VW-1:0] dsr_q;
	logic [CW-1:0] cnt_q;
	logic          busy_q;
	logic [VW:0]   trial;
	logic [VW:0]   diff;
	logic          ge;

	// one quotient bit a cycle, restoring
	assign trial = {rem_q, quo_q[QW-1]};
	assign diff  = trial - {1'b0, dsr_q};
	assign ge    = trial >= {1'b0, dsr_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q  <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			cnt_q  <= CW'(QW);
		end else if (busy_q) begin
			cnt_q <= cnt_q - CW'(1);
			if (cnt_q == CW'(1)) begin
				busy_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= dividend[VW+QW-1:QW];
			quo_q <= dividend[QW-1:0];
			dsr_q <= divisor;
		end else if (busy_q) begin
			rem_q <= ge ? diff[VW-1:0] : trial[VW-1:0];
			quo_q <= {quo_q[QW-2:0], ge};
		end
	end

	assign busy     = busy_q;
	assign quotient = quo_q;

endmodule

// ----- rtl/regret_matching_table_unit.sv -----
// regret matching table unit
// req channel: one beat is one command (add regret, add strategy weight,
// regret-matching query, average-strategy query, discount); unused opcodes
// are dropped without a response
// rsp channel: queries give one beat per action, last on the final one;
// discount gives a single beat carrying status; adds give nothing
// one command is in flight at a time; req.ready is high only when idle
// add: the index is reduced by TABLE_DEPTH until it lies in the table,
// then the entry is read and the saturated sum is written back
// query over n actions: the n entries are summed, then each action takes
// one division on the 17-step serial divider
// discount: all TABLE_DEPTH entries are scaled and divided by the
// 32-step serial dividers; an out-of-order iteration answers at once
// reset: a clearing pass over all TABLE_DEPTH entries zeroes both stores,
// req.ready stays low meanwhile
// rsp stall: the response register holds the beat; the unit waits for a free
// register before it produces the next beat
module regret_matching_table_unit #(
	parameter int TABLE_DEPTH = 4096,
	parameter int MAX_ACTIONS = 8
) (
	input  logic clk,
	input  logic arst_n,
	rmt_req_if.sink   req,
	rmt_rsp_if.source rsp
);

	localparam int AW = $clog2(TABLE_DEPTH);
	localparam int NW = $clog2(MAX_ACTIONS + 1);
	localparam int TW = 31 + $clog2(MAX_ACTIONS);
	localparam int RW = rmt_pkg::BASE_W + 1;
	localparam int QW = rmt_pkg::PROB_W;
	localparam int DW = rmt_pkg::VALUE_W;

	rmt_pkg::rmt_state_t state_q, state_d;

	logic [DW-1:0] regret_mem [TABLE_DEPTH];
	logic [DW-1:0] weight_mem [TABLE_DEPTH];
	logic [DW-1:0] reg_rd_q, wgt_rd_q;
	logic          reg_we, wgt_we;
	logic [DW-1:0] reg_wd, wgt_wd;

	logic [AW-1:0] ptr_q, start_ptr_q, ptr_nxt;
	logic          ptr_last;
	logic [RW-1:0] red_q;
	logic          red_ge;
	logic [NW-1:0] k_q, n_q, n_d;
	logic          k_last;
	logic [TW-1:0] total_q;

	logic [rmt_pkg::OPCODE_W-1:0] op_q;
	logic [DW-1:0]                value_q;
	logic [rmt_pkg::ITER_W-1:0]   iter_q, ldi_q;
	logic                         is_add, is_weight;

	logic [DW-1:0] sel_rd;
	logic [30:0]   pos;
	logic [DW:0]   sum;
	logic [DW-1:0] sat;

	logic              qdiv_start, qdiv_busy;
	logic [TW+QW-1:0]  qdiv_dividend;
	logic [TW-1:0]     qdiv_divisor;
	logic [QW-1:0]     qdiv_quo;

	logic              ddiv_start, rdiv_busy, wdiv_busy;
	logic [DW-1:0]     num, den;
	logic [DW-1:0]     reg_mag, wgt_mag;
	logic [2*DW-1:0]   reg_prod_s1, wgt_prod_s1;
	logic              reg_neg_s1, wgt_neg_s1;
	logic [DW-1:0]     reg_quo, wgt_quo;

	logic                        out_vld_q, out_free, out_load;
	logic [QW-1:0]               out_prob_q, out_prob_d;
	logic [rmt_pkg::AIDX_W-1:0]  out_aidx_q, out_aidx_d;
	logic                        out_last_q, out_last_d;
	logic                        out_stat_q, out_stat_d;

	// stores
	always_ff @(posedge clk) begin
		if (reg_we) begin
			regret_mem[ptr_q] <= reg_wd;
		end
		reg_rd_q <= regret_mem[ptr_q];
	end

	always_ff @(posedge clk) begin
		if (wgt_we) begin
			weight_mem[ptr_q] <= wgt_wd;
		end
		wgt_rd_q <= weight_mem[ptr_q];
	end

	assign ptr_last = ptr_q == AW'(TABLE_DEPTH - 1);
	assign ptr_nxt  = ptr_last ? '0 : ptr_q + AW'(1);
	assign red_ge   = 32'(red_q) >= 32'(TABLE_DEPTH);
	assign k_last   = k_q == n_q - NW'(1);
	assign out_free = !out_vld_q || rsp.ready;

	assign is_add    = op_q == rmt_pkg::OP_ADD_REGRET || op_q == rmt_pkg::OP_ADD_WEIGHT;
	assign is_weight = op_q == rmt_pkg::OP_ADD_WEIGHT || op_q == rmt_pkg::OP_AVG_QUERY;

	assign sel_rd = is_weight ? wgt_rd_q : reg_rd_q;
	assign pos    = sel_rd[DW-1] ? '0 : sel_rd[30:0];
	assign sum    = {sel_rd[DW-1], sel_rd} + {value_q[DW-1], value_q};
	assign sat    = (sum[DW] != sum[DW-1]) ? (sum[DW] ? rmt_pkg::SAT_MIN : rmt_pkg::SAT_MAX)
		: sum[DW-1:0];

	always_comb begin
		if (req.action_count == '0) begin
			n_d = NW'(1);
		end else if (32'(req.action_count) > 32'(MAX_ACTIONS)) begin
			n_d = NW'(MAX_ACTIONS);
		end else begin
			n_d = NW'(req.action_count);
		end
	end

	// query divider: p * 65536 / total, or 65536 / n when the total is zero
	always_comb begin
		if (total_q == '0) begin
			qdiv_dividend = (TW+QW)'(rmt_pkg::Q16_ONE);
			qdiv_divisor  = TW'(n_q);
		end else begin
			qdiv_dividend = (TW+QW)'({pos, {rmt_pkg::FRAC_W{1'b0}}});
			qdiv_divisor  = total_q;
		end
	end

	rmt_div #(.VW(TW), .QW(QW)) u_qdiv (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (qdiv_start),
		.dividend (qdiv_dividend),
		.divisor  (qdiv_divisor),
		.busy     (qdiv_busy),
		.quotient (qdiv_quo)
	);

	// discount: magnitude times (last+1), then divide by (t+1)
	assign num     = {1'b0, ldi_q} + DW'(1);
	assign den     = {1'b0, iter_q} + DW'(1);
	assign reg_mag = reg_rd_q[DW-1] ? -reg_rd_q : reg_rd_q;
	assign wgt_mag = wgt_rd_q[DW-1] ? -wgt_rd_q : wgt_rd_q;

	always_ff @(posedge clk) begin
		if (state_q == rmt_pkg::S_D_MUL) begin
			reg_prod_s1 <= reg_mag * num;
			wgt_prod_s1 <= wgt_mag * num;
			reg_neg_s1  <= reg_rd_q[DW-1];
			wgt_neg_s1  <= wgt_rd_q[DW-1];
		end
	end

	rmt_div #(.VW(DW), .QW(DW)) u_rdiv (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (ddiv_start),
		.dividend (reg_prod_s1),
		.divisor  (den),
		.busy     (rdiv_busy),
		.quotient (reg_quo)
	);

	rmt_div #(.VW(DW), .QW(DW)) u_wdiv (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (ddiv_start),
		.dividend (wgt_prod_s1),
		.divisor  (den),
		.busy     (wdiv_busy),
		.quotient (wgt_quo)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= rmt_pkg::S_CLEAR;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d    = state_q;
		reg_we     = 1'b0;
		wgt_we     = 1'b0;
		reg_wd     = '0;
		wgt_wd     = '0;
		qdiv_start = 1'b0;
		ddiv_start = 1'b0;
		out_load   = 1'b0;
		out_prob_d = '0;
		out_aidx_d = '0;
		out_last_d = 1'b1;
		out_stat_d = rmt_pkg::ST_OK;
		case (state_q)
			rmt_pkg::S_CLEAR: begin
				reg_we = 1'b1;
				wgt_we = 1'b1;
				if (ptr_last) begin
					state_d = rmt_pkg::S_IDLE;
				end
			end
			rmt_pkg::S_IDLE: begin
				if (req.valid) begin
					case (req.opcode)
						rmt_pkg::OP_ADD_REGRET, rmt_pkg::OP_ADD_WEIGHT,
						rmt_pkg::OP_RM_QUERY, rmt_pkg::OP_AVG_QUERY: begin
							state_d = rmt_pkg::S_REDUCE;
						end
						rmt_pkg::OP_DISCOUNT: begin
							state_d = (req.iteration <= ldi_q) ? rmt_pkg::S_ERR_EMIT
								: rmt_pkg::S_D_RD;
						end
						default: state_d = rmt_pkg::S_IDLE;
					endcase
				end
			end
			rmt_pkg::S_REDUCE: begin
				if (!red_ge) begin
					state_d = is_add ? rmt_pkg::S_ADD_RD : rmt_pkg::S_SUM_RD;
				end
			end
			rmt_pkg::S_ADD_RD: state_d = rmt_pkg::S_ADD_WR;
			rmt_pkg::S_ADD_WR: begin
				reg_we  = !is_weight;
				wgt_we  = is_weight;
				reg_wd  = sat;
				wgt_wd  = sat;
				state_d = rmt_pkg::S_IDLE;
			end
			rmt_pkg::S_SUM_RD: state_d = rmt_pkg::S_SUM_ACC;
			rmt_pkg::S_SUM_ACC: state_d = k_last ? rmt_pkg::S_Q_RD : rmt_pkg::S_SUM_RD;
			rmt_pkg::S_Q_RD: state_d = rmt_pkg::S_Q_DIV;
			rmt_pkg::S_Q_DIV: begin
				qdiv_start = 1'b1;
				state_d    = rmt_pkg::S_Q_WAIT;
			end
			rmt_pkg::S_Q_WAIT: begin
				if (!qdiv_busy) begin
					state_d = rmt_pkg::S_Q_EMIT;
				end
			end
			rmt_pkg::S_Q_EMIT: begin
				out_prob_d = qdiv_quo;
				out_aidx_d = rmt_pkg::AIDX_W'(k_q);
				out_last_d = k_last;
				if (out_free) begin
					out_load = 1'b1;
					state_d  = k_last ? rmt_pkg::S_IDLE : rmt_pkg::S_Q_RD;
				end
			end
			rmt_pkg::S_D_RD: state_d = rmt_pkg::S_D_MUL;
			rmt_pkg::S_D_MUL: state_d = rmt_pkg::S_D_DIV;
			rmt_pkg::S_D_DIV: begin
				ddiv_start = 1'b1;
				state_d    = rmt_pkg::S_D_WAIT;
			end
			rmt_pkg::S_D_WAIT: begin
				if (!rdiv_busy && !wdiv_busy) begin
					state_d = rmt_pkg::S_D_WR;
				end
			end
			rmt_pkg::S_D_WR: begin
				reg_we  = 1'b1;
				wgt_we  = 1'b1;
				reg_wd  = reg_neg_s1 ? -reg_quo : reg_quo;
				wgt_wd  = wgt_neg_s1 ? -wgt_quo : wgt_quo;
				state_d = ptr_last ? rmt_pkg::S_D_EMIT : rmt_pkg::S_D_RD;
			end
			rmt_pkg::S_D_EMIT: begin
				if (out_free) begin
					out_load = 1'b1;
					state_d  = rmt_pkg::S_IDLE;
				end
			end
			rmt_pkg::S_ERR_EMIT: begin
				out_stat_d = rmt_pkg::ST_ORDER;
				if (out_free) begin
					out_load = 1'b1;
					state_d  = rmt_pkg::S_IDLE;
				end
			end
			default: state_d = rmt_pkg::S_IDLE;
		endcase
	end

	// control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ptr_q     <= '0;
			k_q       <= '0;
			ldi_q     <= '0;
			out_vld_q <= 1'b0;
		end else begin
			case (state_q)
				rmt_pkg::S_CLEAR: ptr_q <= ptr_nxt;
				rmt_pkg::S_IDLE: begin
					k_q   <= '0;
					ptr_q <= '0;
				end
				rmt_pkg::S_REDUCE: begin
					if (!red_ge) begin
						ptr_q <= AW'(red_q);
					end
				end
				rmt_pkg::S_SUM_ACC: begin
					if (k_last) begin
						k_q   <= '0;
						ptr_q <= start_ptr_q;
					end else begin
						k_q   <= k_q + NW'(1);
						ptr_q <= ptr_nxt;
					end
				end
				rmt_pkg::S_Q_EMIT: begin
					if (out_free) begin
						k_q   <= k_q + NW'(1);
						ptr_q <= ptr_nxt;
					end
				end
				rmt_pkg::S_D_WR: ptr_q <= ptr_nxt;
				rmt_pkg::S_D_EMIT: begin
					if (out_free) begin
						ldi_q <= iter_q;
					end
				end
				default: ;
			endcase
			if (out_load) begin
				out_vld_q <= 1'b1;
			end else if (rsp.ready) begin
				out_vld_q <= 1'b0;
			end
		end
	end

	// command and response payload
	always_ff @(posedge clk) begin
		if (state_q == rmt_pkg::S_IDLE && req.valid) begin
			op_q    <= req.opcode;
			value_q <= req.value;
			iter_q  <= req.iteration;
			n_q     <= n_d;
			total_q <= '0;
			if (req.opcode == rmt_pkg::OP_ADD_REGRET || req.opcode == rmt_pkg::OP_ADD_WEIGHT) begin
				red_q <= RW'(req.base_index) + RW'(req.action_slot);
			end else begin
				red_q <= RW'(req.base_index);
			end
		end
		if (state_q == rmt_pkg::S_REDUCE) begin
			if (red_ge) begin
				red_q <= red_q - RW'(TABLE_DEPTH);
			end else begin
				start_ptr_q <= AW'(red_q);
			end
		end
		if (state_q == rmt_pkg::S_SUM_ACC) begin
			total_q <= total_q + TW'(pos);
		end
		if (out_load) begin
			out_prob_q <= out_prob_d;
			out_aidx_q <= out_aidx_d;
			out_last_q <= out_last_d;
			out_stat_q <= out_stat_d;
		end
	end

	assign req.ready        = state_q == rmt_pkg::S_IDLE;
	assign rsp.valid        = out_vld_q;
	assign rsp.probability  = out_prob_q;
	assign rsp.action_index = out_aidx_q;
	assign rsp.last         = out_last_q;
	assign rsp.status       = out_stat_q;

endmodule

// ----- rtl/rmt_checker.sv -----
module rmt_checker (
	input logic                          clk,
	input logic                          arst_n,
	input logic                          req_valid,
	input logic                          req_ready,
	input logic [rmt_pkg::OPCODE_W-1:0]  req_opcode,
	input logic                          rsp_valid,
	input logic                          rsp_ready,
	input logic [rmt_pkg::PROB_W-1:0]    rsp_probability,
	input logic [rmt_pkg::AIDX_W-1:0]    rsp_action_index,
	input logic                          rsp_last,
	input logic                          rsp_status
);

	// stalled beat holds
	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_probability)
			&& $stable(rsp_action_index) && $stable(rsp_last) && $stable(rsp_status))
		else $error("rsp beat changed while stalled");

	a_prob_range: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid |-> rsp_probability <= rmt_pkg::Q16_ONE)
		else $error("probability above one");

	a_err_beat: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp_status == rmt_pkg::ST_ORDER |-> rsp_last
			&& rsp_probability == '0 && rsp_action_index == '0)
		else $error("malformed error beat");

	// a real command keeps the unit busy for at least the next cycle
	a_busy_after: assert property (@(posedge clk) disable iff (!arst_n)
		req_valid && req_ready && req_opcode <= rmt_pkg::OP_DISCOUNT |=> !req_ready)
		else $error("ready straight after a command");

endmodule

bind regret_matching_table_unit rmt_checker u_rmt_checker (
	.clk              (clk),
	.arst_n           (arst_n),
	.req_valid        (req.valid),
	.req_ready        (req.ready),
	.req_opcode       (req.opcode),
	.rsp_valid        (rsp.valid),
	.rsp_ready        (rsp.ready),
	.rsp_probability  (rsp.probability),
	.rsp_action_index (rsp.action_index),
	.rsp_last         (rsp.last),
	.rsp_status       (rsp.status)
);
